// ===== hw/rtl/hgge_pkg.sv =====
// ----------------------------------------------------------------------------
// hgge_pkg
// Shared types and constants of the height grid gradient and extreme search.
// ----------------------------------------------------------------------------
package hgge_pkg;

    // Grid size limits; the store holds MAX_WIDTH columns of MAX_HEIGHT rows
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // Field widths
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 6;
    localparam int HGT_W     = 16;
    localparam int GRAD_W    = 18;

    // Coordinate and address widths follow from the grid limits
    localparam int X_W       = $clog2(MAX_WIDTH);
    localparam int Y_W       = $clog2(MAX_HEIGHT);
    localparam int ADDR_W    = X_W + Y_W;
    localparam int MEM_DEPTH = MAX_WIDTH * (2 ** Y_W);

    // Width that holds a map dimension, a config value and a limit
    localparam int DIM_X_W = $clog2(MAX_WIDTH + 1);
    localparam int DIM_Y_W = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_XY_W = (DIM_X_W > DIM_Y_W) ? DIM_X_W : DIM_Y_W;
    localparam int DIM_W = (DIM_XY_W > CFG_W) ? DIM_XY_W : CFG_W;

    localparam logic signed [HGT_W-1:0] EMPTY_CODE = {1'b1, {(HGT_W-1){1'b0}}};
    localparam logic [CFG_W-1:0] MAP_DIM_RESET = CFG_W'(64);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ACT_WRITE    = 2'd0,
        ACT_GRAD     = 2'd1,
        ACT_FIND_MAX = 2'd2,
        ACT_FIND_MIN = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OUT   = 2'd1,
        ST_NORES = 2'd2
    } rsp_status_t;

    typedef enum logic [1:0] {
        RD_CENTER = 2'd0,
        RD_BEFORE = 2'd1,
        RD_AFTER  = 2'd2,
        RD_SCAN   = 2'd3
    } rd_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    clr_wr;
        logic    cell_wr;
        rd_sel_t rd_sel;
        logic    cap_c;
        logic    cap_b;
        logic    cap_a;
        logic    scan_issue;
        logic    res_load;
    } hgge_ctl_t;

    // Datapath to controller
    typedef struct packed {
        action_t in_action;
        logic    in_map;
        logic    item_in_map;
        logic    map_empty;
        logic    clr_last;
        logic    scan_last;
    } hgge_sts_t;

endpackage

// ===== hw/rtl/hgge_cmd_if.sv =====
// ----------------------------------------------------------------------------
// hgge_cmd_if
// Request channel: one action with its position, axis and height.
// ----------------------------------------------------------------------------
interface hgge_cmd_if import hgge_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic                    axis;
    logic signed [HGT_W-1:0] height;

    modport source (
        output valid, action, pos_x, pos_y, axis, height,
        input  ready
    );

    modport sink (
        input  valid, action, pos_x, pos_y, axis, height,
        output ready
    );

endinterface

// ===== hw/rtl/hgge_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hgge_rsp_if
// Result channel: status, gradient and extreme cell.
// ----------------------------------------------------------------------------
interface hgge_rsp_if import hgge_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [GRAD_W-1:0] gradient;
    logic [POS_W-1:0]         found_x;
    logic [POS_W-1:0]         found_y;
    logic signed [HGT_W-1:0]  found_height;

    modport source (
        output valid, status, gradient, found_x, found_y, found_height,
        input  ready
    );

    modport sink (
        input  valid, status, gradient, found_x, found_y, found_height,
        output ready
    );

endinterface

// ===== hw/rtl/hgge_ram.sv =====
// ----------------------------------------------------------------------------
// hgge_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hgge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hgge_ctrl.sv =====
// ----------------------------------------------------------------------------
// hgge_ctrl
// Sequencer: clearing sweep, action dispatch, reads, scan and result hand-off.
// ----------------------------------------------------------------------------
module hgge_ctrl import hgge_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  hgge_sts_t sts,
    output hgge_ctl_t ctl
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_WR       = 9'b000000100,
        S_RD_C     = 9'b000001000,
        S_RD_B     = 9'b000010000,
        S_RD_A     = 9'b000100000,
        S_GRAD     = 9'b001000000,
        S_SCAN     = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   scan_end_reg;
    logic   scan_end_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        scan_end_next = 1'b0;
        ctl           = '0;
        ctl.rd_sel    = RD_CENTER;
        cmd_ready     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load = 1'b1;
                    unique case (sts.in_action)
                        ACT_WRITE:    state_next = S_WR;
                        ACT_GRAD:     state_next = sts.in_map ? S_RD_C : S_DONE;
                        ACT_FIND_MAX,
                        ACT_FIND_MIN: state_next = sts.map_empty ? S_DONE : S_SCAN;
                    endcase
                end
            end
            S_WR:
            begin
                ctl.cell_wr = sts.item_in_map;
                state_next  = S_DONE;
            end
            S_RD_C:
            begin
                ctl.rd_sel = RD_CENTER;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                ctl.rd_sel = RD_BEFORE;
                ctl.cap_c  = 1'b1;
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                ctl.rd_sel = RD_AFTER;
                ctl.cap_b  = 1'b1;
                state_next = S_GRAD;
            end
            S_GRAD:
            begin
                ctl.cap_a  = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // last read issued: its data is compared during the next cycle
                ctl.rd_sel     = RD_SCAN;
                ctl.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    scan_end_next = 1'b1;
                end
                if (scan_end_reg)
                begin
                    ctl.rd_sel     = RD_CENTER;
                    ctl.scan_issue = 1'b0;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_end_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_end_reg  <= scan_end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start work");

    a_no_result_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !rsp_valid_reg)
        else $error("result pending during clearing sweep");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> rsp_valid_reg)
        else $error("result beat dropped while stalled");

endmodule

// ===== hw/rtl/hgge_dp.sv =====
// ----------------------------------------------------------------------------
// hgge_dp
// Datapath: config registers, height store, neighbor reads, scan and result.
// ----------------------------------------------------------------------------
module hgge_dp import hgge_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hgge_ctl_t                 ctl,
    output hgge_sts_t                 sts,
    input  logic [1:0]                action,
    input  logic [POS_W-1:0]          pos_x,
    input  logic [POS_W-1:0]          pos_y,
    input  logic                      axis,
    input  logic signed [HGT_W-1:0]   height,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_idx,
    input  logic [CFG_W-1:0]          cfg_wdata,
    output logic [1:0]                status,
    output logic signed [GRAD_W-1:0]  gradient,
    output logic [POS_W-1:0]          found_x,
    output logic [POS_W-1:0]          found_y,
    output logic signed [HGT_W-1:0]   found_height
);

    logic [CFG_W-1:0] map_width_reg;
    logic [CFG_W-1:0] map_height_reg;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;

    // Latched item
    action_t                 action_reg;
    logic [X_W-1:0]          cx_reg;
    logic [Y_W-1:0]          cy_reg;
    logic                    axis_reg;
    logic signed [HGT_W-1:0] height_reg;
    logic                    in_map_reg;
    logic                    b_in_reg;
    logic                    a_in_reg;

    logic signed [HGT_W-1:0] c_reg;
    logic signed [HGT_W-1:0] b_reg;
    logic signed [HGT_W-1:0] a_reg;

    // Scan
    logic [X_W-1:0]          scan_x_reg;
    logic [Y_W-1:0]          scan_y_reg;
    logic                    pend_reg;
    logic [X_W-1:0]          pend_x_reg;
    logic [Y_W-1:0]          pend_y_reg;
    logic                    found_reg;
    logic signed [HGT_W-1:0] best_reg;
    logic [X_W-1:0]          best_x_reg;
    logic [Y_W-1:0]          best_y_reg;
    logic                    y_last;
    logic                    upd;

    logic [ADDR_W-1:0]       clr_addr_reg;

    // Result register
    rsp_status_t              status_reg;
    logic signed [GRAD_W-1:0] gradient_reg;
    logic [POS_W-1:0]         found_x_reg;
    logic [POS_W-1:0]         found_y_reg;
    logic signed [HGT_W-1:0]  found_height_reg;

    rsp_status_t              status_next;
    logic signed [GRAD_W-1:0] gradient_next;
    logic [POS_W-1:0]         found_x_next;
    logic [POS_W-1:0]         found_y_next;
    logic signed [HGT_W-1:0]  found_height_next;

    logic [DIM_W-1:0]        px_ext;
    logic [DIM_W-1:0]        py_ext;
    logic                    in_map_now;
    logic                    b_in_now;
    logic                    a_in_now;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [HGT_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [HGT_W-1:0]        mem_rdata;
    logic signed [HGT_W-1:0] rd_val;

    logic                     lok;
    logic                     rok;
    logic signed [GRAD_W-1:0] diff_ab;
    logic signed [GRAD_W-1:0] diff_ac;
    logic signed [GRAD_W-1:0] diff_cb;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_DIM_RESET;
            map_height_reg <= MAP_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_wdata;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_wdata;
            endcase
        end
    end

    assign eff_w = (DIM_W'(map_width_reg) > DIM_W'(MAX_WIDTH)) ?
                   DIM_W'(MAX_WIDTH) : DIM_W'(map_width_reg);
    assign eff_h = (DIM_W'(map_height_reg) > DIM_W'(MAX_HEIGHT)) ?
                   DIM_W'(MAX_HEIGHT) : DIM_W'(map_height_reg);

    // ---------------- item decode ----------------
    assign px_ext     = DIM_W'(pos_x);
    assign py_ext     = DIM_W'(pos_y);
    assign in_map_now = (px_ext < eff_w) && (py_ext < eff_h);
    assign b_in_now   = axis ? (pos_y != '0) : (pos_x != '0);
    assign a_in_now   = axis ? ((py_ext + DIM_W'(1)) < eff_h)
                             : ((px_ext + DIM_W'(1)) < eff_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_WRITE;
        end
        else if (ctl.load)
        begin
            action_reg <= action_t'(action);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cx_reg     <= X_W'(pos_x);
            cy_reg     <= Y_W'(pos_y);
            axis_reg   <= axis;
            height_reg <= height;
            in_map_reg <= in_map_now;
            b_in_reg   <= b_in_now;
            a_in_reg   <= a_in_now;
        end
        if (ctl.cap_c)
        begin
            c_reg <= rd_val;
        end
        if (ctl.cap_b)
        begin
            b_reg <= rd_val;
        end
        if (ctl.cap_a)
        begin
            a_reg <= rd_val;
        end
    end

    // ---------------- height store ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (ctl.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign mem_we    = ctl.clr_wr || ctl.cell_wr;
    assign mem_waddr = ctl.clr_wr ? clr_addr_reg : {cx_reg, cy_reg};
    assign mem_wdata = ctl.clr_wr ? EMPTY_CODE : height_reg;

    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_CENTER: mem_raddr = {cx_reg, cy_reg};
            RD_BEFORE: mem_raddr = axis_reg ? {cx_reg, cy_reg - Y_W'(1)}
                                            : {cx_reg - X_W'(1), cy_reg};
            RD_AFTER:  mem_raddr = axis_reg ? {cx_reg, cy_reg + Y_W'(1)}
                                            : {cx_reg + X_W'(1), cy_reg};
            RD_SCAN:   mem_raddr = {scan_x_reg, scan_y_reg};
        endcase
    end

    hgge_ram #(
        .WIDTH (HGT_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_val = mem_rdata;

    // ---------------- extreme scan ----------------
    assign y_last = (DIM_W'(scan_y_reg) == (eff_h - DIM_W'(1)));
    assign upd    = pend_reg && (rd_val != EMPTY_CODE) &&
                    (!found_reg || ((action_reg == ACT_FIND_MAX) ? (rd_val > best_reg)
                                                                 : (rd_val < best_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.scan_issue;
            if (ctl.load)
            begin
                found_reg <= 1'b0;
            end
            else if (upd)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            scan_x_reg <= '0;
            scan_y_reg <= '0;
        end
        else if (ctl.scan_issue)
        begin
            // x-major walk: y runs fastest
            if (y_last)
            begin
                scan_y_reg <= '0;
                scan_x_reg <= scan_x_reg + X_W'(1);
            end
            else
            begin
                scan_y_reg <= scan_y_reg + Y_W'(1);
            end
        end
        if (ctl.scan_issue)
        begin
            pend_x_reg <= scan_x_reg;
            pend_y_reg <= scan_y_reg;
        end
        if (upd)
        begin
            best_reg   <= rd_val;
            best_x_reg <= pend_x_reg;
            best_y_reg <= pend_y_reg;
        end
    end

    // ---------------- result ----------------
    assign lok     = b_in_reg && (b_reg != EMPTY_CODE);
    assign rok     = a_in_reg && (a_reg != EMPTY_CODE);
    assign diff_ab = GRAD_W'(a_reg) - GRAD_W'(b_reg);
    assign diff_ac = GRAD_W'(a_reg) - GRAD_W'(c_reg);
    assign diff_cb = GRAD_W'(c_reg) - GRAD_W'(b_reg);

    always_comb
    begin
        status_next       = ST_OK;
        gradient_next     = '0;
        found_x_next      = '0;
        found_y_next      = '0;
        found_height_next = EMPTY_CODE;
        unique case (action_reg)
            ACT_WRITE:
            begin
                if (!in_map_reg)
                begin
                    status_next = ST_OUT;
                end
            end
            ACT_GRAD:
            begin
                priority if (!in_map_reg)
                    status_next = ST_OUT;
                else if (c_reg == EMPTY_CODE)
                    status_next = ST_NORES;
                else if (lok && rok)
                    gradient_next = diff_ab;
                else if (rok)
                    gradient_next = diff_ac <<< 1;
                else if (lok)
                    gradient_next = diff_cb <<< 1;
                else
                    status_next = ST_NORES;
            end
            ACT_FIND_MAX,
            ACT_FIND_MIN:
            begin
                if (found_reg)
                begin
                    found_x_next      = POS_W'(best_x_reg);
                    found_y_next      = POS_W'(best_y_reg);
                    found_height_next = best_reg;
                end
                else
                begin
                    status_next = ST_NORES;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            status_reg       <= status_next;
            gradient_reg     <= gradient_next;
            found_x_reg      <= found_x_next;
            found_y_reg      <= found_y_next;
            found_height_reg <= found_height_next;
        end
    end

    assign status       = status_reg;
    assign gradient     = gradient_reg;
    assign found_x      = found_x_reg;
    assign found_y      = found_y_reg;
    assign found_height = found_height_reg;

    assign sts.in_action   = action_t'(action);
    assign sts.in_map      = in_map_now;
    assign sts.item_in_map = in_map_reg;
    assign sts.map_empty   = (eff_w == '0) || (eff_h == '0);
    assign sts.clr_last    = (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1));
    assign sts.scan_last   = y_last && (DIM_W'(scan_x_reg) == (eff_w - DIM_W'(1)));

    a_write_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cell_wr |-> in_map_reg)
        else $error("cell write outside the map");

    a_scan_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_issue |-> ((DIM_W'(scan_x_reg) < eff_w) && (DIM_W'(scan_y_reg) < eff_h)))
        else $error("scan address outside the map");

    a_found_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_reg != EMPTY_CODE))
        else $error("extreme holds the empty code");

endmodule

// ===== hw/rtl/height_grid_gradient_extrema.sv =====
// ----------------------------------------------------------------------------
// height_grid_gradient_extrema
// A write stores its cell and goes to the result; an in-map gradient first reads
// the centre, before and after cells in turn, as the store has a single read port;
// a search reads every cell of the effective map; an out-of-map gradient or a
// search on an empty map goes straight to the result. One beat is taken per item;
// the next beat is accepted only once the result of the last one is registered.
// Reset clears the store with a sweep of all MAX_WIDTH*2^clog2(MAX_HEIGHT)
// addresses (4096) during which no beat is accepted; config writes still land.
// ----------------------------------------------------------------------------
module height_grid_gradient_extrema import hgge_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    hgge_cmd_if.sink             cmd,
    hgge_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    hgge_ctl_t ctl;
    hgge_sts_t sts;

    hgge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    hgge_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .action       (cmd.action),
        .pos_x        (cmd.pos_x),
        .pos_y        (cmd.pos_y),
        .axis         (cmd.axis),
        .height       (cmd.height),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .status       (rsp.status),
        .gradient     (rsp.gradient),
        .found_x      (rsp.found_x),
        .found_y      (rsp.found_y),
        .found_height (rsp.found_height)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the height grid gradient and extreme search block.
// A local model of the grid predicts every result beat; a checker compares
// each beat field by field. Directed cases come first, then randomized
// phases over many map sizes with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import hgge_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RAND_PHASES  = 24;
    localparam int PHASE_ITEMS  = 82;

    typedef struct {
        action_t                 act;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic                    ax;
        logic signed [HGT_W-1:0] h;
    } grid_cmd_t;

    typedef struct {
        rsp_status_t              status;
        logic signed [GRAD_W-1:0] gradient;
        logic [POS_W-1:0]         fx;
        logic [POS_W-1:0]         fy;
        logic signed [HGT_W-1:0]  fh;
    } grid_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    hgge_cmd_if cmd_bus ();
    hgge_rsp_if rsp_bus ();

    height_grid_gradient_extrema uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // Local copy of the grid and the map size registers
    logic signed [HGT_W-1:0] heights [MAX_WIDTH][MAX_HEIGHT];
    logic [CFG_W-1:0]        map_w;
    logic [CFG_W-1:0]        map_h;

    grid_result_t pending_results [$];
    grid_result_t head_result;

    bit src_gaps;
    bit sink_stalls;
    int stall_left;
    int cycle_count;
    int errors;
    int n_checked;
    int n_writes;
    int n_grads;
    int n_searches;
    int n_settings;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic bit cell_has_data(int x, int y, int ew, int eh);
        return x >= 0 && y >= 0 && x < ew && y < eh && heights[x][y] != EMPTY_CODE;
    endfunction

    // Applies one command to the local grid and returns the result it gives
    function automatic grid_result_t predict_grid_result(grid_cmd_t c);
        grid_result_t r;
        int  ew, eh, px, py, dx, dy, centre, lo, hi, g, v, best;
        bit  lok, rok, found;
        ew = eff_dim(map_w, MAX_WIDTH);
        eh = eff_dim(map_h, MAX_HEIGHT);
        px = int'(c.x);
        py = int'(c.y);
        r.status   = ST_OK;
        r.gradient = '0;
        r.fx       = '0;
        r.fy       = '0;
        r.fh       = EMPTY_CODE;
        if (c.act == ACT_WRITE || c.act == ACT_GRAD)
        begin
            if (px >= ew || py >= eh)
                r.status = ST_OUT;
            else if (c.act == ACT_WRITE)
                heights[px][py] = c.h;
            else
            begin
                dx = c.ax ? 0 : 1;
                dy = c.ax ? 1 : 0;
                centre = int'(heights[px][py]);
                lok = cell_has_data(px - dx, py - dy, ew, eh);
                rok = cell_has_data(px + dx, py + dy, ew, eh);
                lo = lok ? int'(heights[px - dx][py - dy]) : 0;
                hi = rok ? int'(heights[px + dx][py + dy]) : 0;
                if (heights[px][py] == EMPTY_CODE || !(lok || rok))
                    r.status = ST_NORES;
                else
                begin
                    if (lok && rok)
                        g = hi - lo;
                    else if (rok)
                        g = 2 * (hi - centre);
                    else
                        g = 2 * (centre - lo);
                    r.gradient = GRAD_W'(g);
                end
            end
        end
        else
        begin
            // x-major walk, first strictly better cell wins
            found = 1'b0;
            best  = 0;
            for (int x = 0; x < ew; x++)
            begin
                for (int y = 0; y < eh; y++)
                begin
                    v = int'(heights[x][y]);
                    if (heights[x][y] != EMPTY_CODE &&
                        (!found || (c.act == ACT_FIND_MAX ? v > best : v < best)))
                    begin
                        found = 1'b1;
                        best  = v;
                        r.fx  = POS_W'(x);
                        r.fy  = POS_W'(y);
                    end
                end
            end
            if (found)
                r.fh = HGT_W'(best);
            else
                r.status = ST_NORES;
        end
        return r;
    endfunction

    task automatic send_cmd(action_t act, int x, int y, bit ax, int h);
        grid_cmd_t c;
        c.act = act;
        c.x   = POS_W'(x);
        c.y   = POS_W'(y);
        c.ax  = ax;
        c.h   = HGT_W'(h);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.action <= c.act;
        cmd_bus.pos_x  <= c.x;
        cmd_bus.pos_y  <= c.y;
        cmd_bus.axis   <= c.ax;
        cmd_bus.height <= c.h;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge clk);
        pending_results.push_back(predict_grid_result(c));
        case (act)
            ACT_WRITE: n_writes++;
            ACT_GRAD:  n_grads++;
            default:   n_searches++;
        endcase
    endtask

    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAP_WIDTH)
            map_w = CFG_W'(val);
        else
            map_h = CFG_W'(val);
        @(posedge clk);
    endtask

    task automatic set_map_size(int w, int h);
        drain_results();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        n_settings++;
    endtask

    task automatic flag_field(string fname, logic signed [31:0] want, logic signed [31:0] got);
        errors++;
        $display("%0t result %0d: %s expected %0d, got %0d",
                 $time, n_checked, fname, want, got);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: status %0d", $time, rsp_bus.status);
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (rsp_bus.status !== head_result.status)
                    flag_field("status", int'(head_result.status), int'(rsp_bus.status));
                if (rsp_bus.gradient !== head_result.gradient)
                    flag_field("gradient", int'(head_result.gradient),
                               int'(rsp_bus.gradient));
                if (rsp_bus.found_x !== head_result.fx)
                    flag_field("found_x", int'(head_result.fx), int'(rsp_bus.found_x));
                if (rsp_bus.found_y !== head_result.fy)
                    flag_field("found_y", int'(head_result.fy), int'(rsp_bus.found_y));
                if (rsp_bus.found_height !== head_result.fh)
                    flag_field("found_height", int'(head_result.fh),
                               int'(rsp_bus.found_height));
            end
            n_checked++;
        end
    end

    // Result channel back-pressure: ready is dropped at random while sink_stalls is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 12);
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d results outstanding", $time, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Empty grid after reset: both searches find nothing
    task automatic test_reset_state();
        send_cmd(ACT_FIND_MAX, 0, 0, 1'b0, 0);
        send_cmd(ACT_FIND_MIN, 63, 63, 1'b1, -1);
    endtask

    task automatic test_gradients();
        send_cmd(ACT_WRITE, 10, 20, 1'b0, 100);
        send_cmd(ACT_GRAD, 10, 20, 1'b0, 0);          // no neighbour
        send_cmd(ACT_WRITE, 11, 20, 1'b0, 32767);
        send_cmd(ACT_GRAD, 10, 20, 1'b0, 0);          // after only
        send_cmd(ACT_WRITE, 9, 20, 1'b0, -32767);
        send_cmd(ACT_GRAD, 10, 20, 1'b0, 0);          // central
        send_cmd(ACT_WRITE, 9, 21, 1'b0, 32767);
        send_cmd(ACT_GRAD, 9, 20, 1'b1, 0);           // largest positive
        send_cmd(ACT_WRITE, 63, 62, 1'b0, 32767);
        send_cmd(ACT_WRITE, 63, 63, 1'b0, -32767);
        send_cmd(ACT_GRAD, 63, 63, 1'b1, 0);          // before only, after off map
        send_cmd(ACT_GRAD, 63, 62, 1'b1, 0);          // largest negative
        send_cmd(ACT_GRAD, 63, 63, 1'b0, 0);          // both sides unusable
        send_cmd(ACT_WRITE, 11, 20, 1'b0, int'(EMPTY_CODE));
        send_cmd(ACT_GRAD, 11, 20, 1'b0, 0);          // cleared cell
        send_cmd(ACT_GRAD, 10, 20, 1'b0, 0);
    endtask

    // Ties go to the first cell in x-major order
    task automatic test_extreme_search();
        send_cmd(ACT_WRITE, 0, 5, 1'b0, 32767);
        send_cmd(ACT_FIND_MAX, 0, 0, 1'b0, 0);
        send_cmd(ACT_FIND_MIN, 0, 0, 1'b0, 0);
    endtask

    task automatic test_map_limits();
        set_map_size(0, 64);
        send_cmd(ACT_WRITE, 0, 0, 1'b0, 7);
        send_cmd(ACT_FIND_MAX, 0, 0, 1'b0, 0);
        set_map_size(127, 1);
        send_cmd(ACT_WRITE, 63, 0, 1'b0, -5);
        send_cmd(ACT_GRAD, 10, 20, 1'b0, 0);
        send_cmd(ACT_FIND_MIN, 0, 0, 1'b0, 0);
    endtask

    task automatic test_random_traffic();
        int      w, h, ew, eh, pick, k, x, y, hv;
        bit      big;
        action_t act;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            pick = $urandom_range(0, 11);
            if (p == 1)
                pick = 2;
            else if (p >= RAND_PHASES - 2)
                pick = 11;
            case (pick)
                0:
                begin
                    w = 0;
                    h = $urandom_range(1, 8);
                end
                1:
                begin
                    w = $urandom_range(1, 8);
                    h = 0;
                end
                2:
                begin
                    w = 64;
                    h = 64;
                end
                3:
                begin
                    w = $urandom_range(65, 127);
                    h = $urandom_range(1, 3);
                end
                4:
                begin
                    w = 1;
                    h = $urandom_range(65, 127);
                end
                5:
                begin
                    w = $urandom_range(9, 64);
                    h = $urandom_range(1, 64);
                end
                default:
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
            endcase
            if (p == 2)
            begin
                w = 127;
                h = 127;
            end
            set_map_size(w, h);
            ew  = eff_dim(map_w, MAX_WIDTH);
            eh  = eff_dim(map_h, MAX_HEIGHT);
            big = ew * eh > 64;
            // last stretch runs with no gaps on either side
            src_gaps    = (p < RAND_PHASES - 2) && $urandom_range(0, 2) != 0;
            sink_stalls = (p < RAND_PHASES - 2) && $urandom_range(0, 2) != 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                k = $urandom_range(0, 99);
                if (k < 42)
                    act = ACT_WRITE;
                else if (k < 82)
                    act = ACT_GRAD;
                else if (k < 91)
                    act = ACT_FIND_MAX;
                else
                    act = ACT_FIND_MIN;
                // full scans of a large map are slow; keep them rare
                if (big && act inside {ACT_FIND_MAX, ACT_FIND_MIN} && $urandom_range(0, 9) != 0)
                    act = ACT_GRAD;

                k = $urandom_range(0, 9);
                if (k == 0 || ew == 0 || eh == 0)
                begin
                    x = $urandom_range(0, 63);
                    y = $urandom_range(0, 63);
                end
                else if (k < 5)
                begin
                    x = $urandom_range(0, (ew < 6 ? ew : 6) - 1);
                    y = $urandom_range(0, (eh < 6 ? eh : 6) - 1);
                end
                else
                begin
                    x = $urandom_range(0, ew - 1);
                    y = $urandom_range(0, eh - 1);
                end

                k = $urandom_range(0, 19);
                if (k == 0)
                    hv = int'(EMPTY_CODE);
                else if (k == 1)
                    hv = 32767;
                else if (k == 2)
                    hv = -32767;
                else if (k < 9)
                    hv = $urandom_range(0, 6) - 3;
                else
                    hv = $urandom_range(0, 16'hFFFF);
                send_cmd(act, x, y, 1'($urandom_range(0, 1)), hv);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd_bus.valid  = 1'b0;
        cmd_bus.action = '0;
        cmd_bus.pos_x  = '0;
        cmd_bus.pos_y  = '0;
        cmd_bus.axis   = 1'b0;
        cmd_bus.height = '0;
        rsp_bus.ready  = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_wdata      = '0;
        stall_left     = 0;
        cycle_count    = 0;
        errors         = 0;
        n_checked      = 0;
        n_writes       = 0;
        n_grads        = 0;
        n_searches     = 0;
        n_settings     = 0;
        src_gaps       = 1'b1;
        sink_stalls    = 1'b1;
        map_w          = MAP_DIM_RESET;
        map_h          = MAP_DIM_RESET;
        for (int x = 0; x < MAX_WIDTH; x++)
            for (int y = 0; y < MAX_HEIGHT; y++)
                heights[x][y] = EMPTY_CODE;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_gradients();
        test_extreme_search();
        test_map_limits();
        test_random_traffic();

        drain_results();
        repeat (20) @(posedge clk);

        $display("Ran %0d writes, %0d gradient queries and %0d searches across %0d map sizes;",
                 n_writes, n_grads, n_searches, n_settings);
        $display("%0d result beats compared, %0d field mismatches.", n_checked, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
